FILE: hw/rtl/scp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_pkg: shared types and constants of the sine/cosine generator
// Payload types, fixed-point formats and the Q30 polynomial coefficients.
// ----------------------------------------------------------------------------
package scp_pkg;

	// Payload types.
	typedef logic               op_t;
	typedef logic signed [31:0] angle_t;
	typedef logic signed [17:0] value_t;

	// Operation codes.
	localparam op_t OP_COS = 1'b0;
	localparam op_t OP_SIN = 1'b1;

	// Internal formats.
	typedef logic signed [48:0] xq32_t;   // angle in Q32 radians, sine offset applied
	typedef logic signed [15:0] turn_t;   // whole turn count
	typedef logic signed [51:0] rem_t;    // raw remainder and turn product
	typedef logic        [34:0] red_t;    // remainder in [0, 2pi), Q32
	typedef logic        [30:0] u30_t;    // folded angle, Q30
	typedef logic        [31:0] x2_t;     // square of folded angle, Q30
	typedef logic signed [31:0] acc_t;    // Horner accumulator, Q30

	// Reduction constants in Q32 radians.
	localparam xq32_t HALF_PI_X   = 49'sd6746518852;
	localparam logic signed [30:0] INV_TWO_PI = 31'sd683565276;
	localparam logic signed [35:0] TWO_PI_S   = 36'sd26986075409;

	// Fold thresholds on the reduced angle.
	localparam red_t HALF_PI_R       = 35'd6746518852;
	localparam red_t PI_R            = 35'd13493037705;
	localparam red_t THREE_HALF_PI_R = 35'd20239556557;
	localparam red_t TWO_PI_R        = 35'd26986075409;

	// Polynomial coefficients, Q30.
	localparam acc_t COEF0 = 32'sd1073734624;
	localparam acc_t COEF1 = -32'sd536776893;
	localparam acc_t COEF2 = 32'sd44547129;
	localparam acc_t COEF3 = -32'sd1364951;

	// Output limits.
	localparam logic signed [18:0] ONE_POS = 19'sd65536;
	localparam logic signed [18:0] ONE_NEG = -19'sd65536;
	localparam logic signed [32:0] ROUND_HALF = 33'sd8192;

endpackage

FILE: hw/rtl/scp_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_in_if: request channel of the sine/cosine generator
// Carries valid, ready, the function select and the angle.
// ----------------------------------------------------------------------------
interface scp_in_if;
	import scp_pkg::*;

	logic   valid;
	logic   ready;
	op_t    op;
	angle_t angle;

	modport source (output valid, output op, output angle, input ready);
	modport sink   (input valid, input op, input angle, output ready);
endinterface

FILE: hw/rtl/scp_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_out_if: result channel of the sine/cosine generator
// Carries valid, ready and the Q1.16 result.
// ----------------------------------------------------------------------------
interface scp_out_if;
	import scp_pkg::*;

	logic   valid;
	logic   ready;
	value_t value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

FILE: hw/rtl/scp_horner_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_horner_step: one Horner step of the cosine polynomial
// Returns coef + floor(acc * x2 / 2^30) in Q30.
// ----------------------------------------------------------------------------
module scp_horner_step (
	input  scp_pkg::acc_t acc,
	input  scp_pkg::x2_t  x2,
	input  scp_pkg::acc_t coef,
	output scp_pkg::acc_t result
);
	import scp_pkg::*;

	logic signed [64:0] prod;
	logic signed [35:0] sum;

	always_comb begin
		prod = acc * $signed({1'b0, x2});
		// The upper bits of the product are the floor of the shift.
		sum = 36'(coef) + 36'(prod[64:30]);
		result = sum[31:0];
	end
endmodule

FILE: hw/rtl/sine_cosine_polynomial.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_cosine_polynomial: pipelined sine/cosine generator
// Angle reduction modulo two pi, quadrant fold and a degree-6 polynomial.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while not stalled, each an
// angle in signed Q16.16 radians with op selecting cosine (0) or sine (1),
// and returns cos or sin of it in signed Q1.16, clamped to plus or minus one.
// Every request gives exactly one result, in order. The pipeline has eleven
// register stages and each one is used by one request at a time, so the
// sustained rate is one request per cycle while the result channel is not
// stalled; the deepest stage is a 32 by 33 bit Horner multiply. A stall on
// the result side stops only the stages that are full, so empty stages keep
// filling, and the request channel stays ready until the whole pipe is
// occupied.
// ----------------------------------------------------------------------------
module sine_cosine_polynomial (
	input  logic       clk,
	input  logic       arst_n,
	scp_in_if.sink     request,
	scp_out_if.source  result
);
	import scp_pkg::*;

	localparam int NSTAGE = 11;

	// Stage valid bits and load enables. Stage k loads when it is empty or
	// when the stage after it moves on.
	logic [NSTAGE:1] valid_s;
	logic [NSTAGE:1] stage_en;

	always_comb begin
		stage_en[NSTAGE] = !valid_s[NSTAGE] || result.ready;
		for (int k = NSTAGE - 1; k >= 1; k--) begin
			stage_en[k] = !valid_s[k] || stage_en[k + 1];
		end
	end

	assign request.ready = stage_en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			if (stage_en[1]) begin
				valid_s[1] <= request.valid;
			end
			for (int k = 2; k <= NSTAGE; k++) begin
				if (stage_en[k]) begin
					valid_s[k] <= valid_s[k - 1];
				end
			end
		end
	end

	// Stage 1: scale the angle to Q32 and, for sine, take pi/2 minus it.
	xq32_t x_in;
	xq32_t x_s1;

	always_comb begin
		x_in = {request.angle[31], request.angle, 16'd0};
		if (request.op == OP_SIN) begin
			x_in = HALF_PI_X - x_in;
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			x_s1 <= x_in;
		end
	end

	// Stage 2: turn count from the constant reciprocal of two pi. The
	// arithmetic shifts round toward minus infinity.
	logic signed [63:0] turn_prod;
	turn_t turn_s2;
	xq32_t x_s2;

	assign turn_prod = $signed(x_s1[48:16]) * INV_TWO_PI;

	always_ff @(posedge clk) begin
		if (stage_en[2]) begin
			turn_s2 <= turn_prod[63:48];
			x_s2    <= x_s1;
		end
	end

	// Stage 3: whole turns back in Q32 radians.
	rem_t turns_s3;
	xq32_t x_s3;

	always_ff @(posedge clk) begin
		if (stage_en[3]) begin
			turns_s3 <= rem_t'(turn_s2) * rem_t'(TWO_PI_S);
			x_s3     <= x_s2;
		end
	end

	// Stage 4: raw remainder, which may be off by a turn either way.
	rem_t rem_s4;

	always_ff @(posedge clk) begin
		if (stage_en[4]) begin
			rem_s4 <= rem_t'(x_s3) - turns_s3;
		end
	end

	// Stage 5: bring the remainder into [0, 2pi). All candidates are formed
	// at once and the signs pick one.
	rem_t rem_p1, rem_p2, rem_m1, rem_m2, rem_fix;
	red_t red_s5;

	always_comb begin
		rem_p1 = rem_s4 + rem_t'(TWO_PI_S);
		rem_p2 = rem_p1 + rem_t'(TWO_PI_S);
		rem_m1 = rem_s4 - rem_t'(TWO_PI_S);
		rem_m2 = rem_m1 - rem_t'(TWO_PI_S);
		if (rem_s4 < 0) begin
			rem_fix = (rem_p1 < 0) ? rem_p2 : rem_p1;
		end else if (rem_m1 < 0) begin
			rem_fix = rem_s4;
		end else begin
			rem_fix = (rem_m2 < 0) ? rem_m1 : rem_m2;
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[5]) begin
			red_s5 <= rem_fix[34:0];
		end
	end

	// Stage 6: fold into the first quadrant. The second and third quadrants
	// flip the sign of the result.
	red_t fold_u;
	logic fold_neg;
	u30_t u30_s6;
	logic neg_s6;

	always_comb begin
		fold_neg = 1'b0;
		if (red_s5 < HALF_PI_R) begin
			fold_u = red_s5;
		end else if (red_s5 < PI_R) begin
			fold_u   = PI_R - red_s5;
			fold_neg = 1'b1;
		end else if (red_s5 < THREE_HALF_PI_R) begin
			fold_u   = red_s5 - PI_R;
			fold_neg = 1'b1;
		end else begin
			fold_u = TWO_PI_R - red_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[6]) begin
			u30_s6 <= fold_u[32:2];
			neg_s6 <= fold_neg;
		end
	end

	// Stage 7: square of the folded angle in Q30.
	logic [61:0] u_sq;
	x2_t x2_s7;
	logic neg_s7;

	assign u_sq = u30_s6 * u30_s6;

	always_ff @(posedge clk) begin
		if (stage_en[7]) begin
			x2_s7  <= u_sq[61:30];
			neg_s7 <= neg_s6;
		end
	end

	// Stages 8 to 10: Horner's rule, one coefficient per stage.
	acc_t h1, h2, h3;
	acc_t acc_s8, acc_s9, acc_s10;
	x2_t x2_s8, x2_s9;
	logic neg_s8, neg_s9, neg_s10;

	scp_horner_step u_step1 (.acc(COEF3),  .x2(x2_s7), .coef(COEF2), .result(h1));
	scp_horner_step u_step2 (.acc(acc_s8), .x2(x2_s8), .coef(COEF1), .result(h2));
	scp_horner_step u_step3 (.acc(acc_s9), .x2(x2_s9), .coef(COEF0), .result(h3));

	always_ff @(posedge clk) begin
		if (stage_en[8]) begin
			acc_s8 <= h1;
			x2_s8  <= x2_s7;
			neg_s8 <= neg_s7;
		end
		if (stage_en[9]) begin
			acc_s9 <= h2;
			x2_s9  <= x2_s8;
			neg_s9 <= neg_s8;
		end
		if (stage_en[10]) begin
			acc_s10 <= h3;
			neg_s10 <= neg_s9;
		end
	end

	// Stage 11: round half up to Q16, clamp to plus or minus one, apply the
	// fold sign. This is the output register.
	logic signed [32:0] rnd_sum;
	logic signed [18:0] rnd_v, clamp_v;
	value_t value_s11;

	always_comb begin
		rnd_sum = 33'(acc_s10) + ROUND_HALF;
		rnd_v   = rnd_sum[32:14];
		if (rnd_v > ONE_POS) begin
			clamp_v = ONE_POS;
		end else if (rnd_v < ONE_NEG) begin
			clamp_v = ONE_NEG;
		end else begin
			clamp_v = rnd_v;
		end
		if (neg_s10) begin
			clamp_v = -clamp_v;
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[11]) begin
			value_s11 <= clamp_v[17:0];
		end
	end

	assign result.valid = valid_s[NSTAGE];
	assign result.value = value_s11;

endmodule
